@@ hw/rtl/fr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fr_pkg
// shared widths and fixed-point constants of the fresnel reflectance block
// ----------------------------------------------------------------------------
package fr_pkg;

	localparam int unsigned COORD_W = 16;   // signed q2.14 vector component
	localparam int unsigned IOR_W   = 16;   // unsigned q4.12 index
	localparam int unsigned REFL_W  = 17;   // unsigned q1.16 reflectance
	localparam int unsigned DOT_W   = 34;   // exact dot product, q.28
	localparam int unsigned COS_W   = 29;   // q0.28, up to 1.0
	localparam int unsigned SQ_W    = 57;   // square of a q0.28 value
	localparam int unsigned C16_W   = 17;   // q0.16, up to 1.0
	localparam int unsigned TERM_W  = 33;   // index times q0.16 cosine
	localparam int unsigned RATIO_W = 31;   // q0.30 ratio magnitude
	localparam int unsigned RFRAC   = 30;

	localparam logic [IOR_W-1:0]  ONE_Q12   = 16'd4096;
	localparam logic [IOR_W-1:0]  MIN_INDEX = 16'd1024;
	localparam logic [SQ_W-1:0]   ONE_SQ    = 57'd1 << 56;
	localparam logic [RATIO_W-1:0] RATIO_ONE = 31'd1 << 30;
	localparam logic [REFL_W-1:0] REFL_ONE  = 17'd65536;

endpackage

@@ hw/rtl/fr_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fr_sqrt
// pipelined floor square root, one root bit per stage, side data carried along
// ----------------------------------------------------------------------------
module fr_sqrt
	import fr_pkg::*;
#(
	parameter int unsigned W  = SQ_W,
	parameter int unsigned SW = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   vin,
	input  logic [W-1:0]           rad,
	input  logic [SW-1:0]          side_i,
	output logic                   vout,
	output logic [(W+1)/2-1:0]     root,
	output logic [SW-1:0]          side_o
);

	localparam int unsigned RW = (W + 1) / 2;
	localparam int unsigned AW = 2 * RW;

	logic          v_s    [0:RW];
	logic [AW-1:0] rem_s  [0:RW];
	logic [RW-1:0] root_s [0:RW];
	logic [SW-1:0] side_s [0:RW];

	assign v_s[0]    = vin;
	assign rem_s[0]  = AW'(rad);
	assign root_s[0] = '0;
	assign side_s[0] = side_i;

	for (genvar i = 0; i < RW; i++) begin : g_stage
		localparam int unsigned K = RW - 1 - i;
		logic [AW-1:0] cand;
		logic          take;

		always_comb begin
			cand = (AW'(root_s[i]) << (K + 1)) | (AW'(1) << (2 * K));
			take = rem_s[i] >= cand;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= take ? rem_s[i] - cand : rem_s[i];
				root_s[i+1] <= take ? root_s[i] | (RW'(1) << K) : root_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign vout   = v_s[RW];
	assign root   = root_s[RW];
	assign side_o = side_s[RW];

endmodule

@@ hw/rtl/fr_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fr_div
// pipelined restoring divider, one quotient bit per stage
// expects num < den << QW; side data carried along
// ----------------------------------------------------------------------------
module fr_div
	import fr_pkg::*;
#(
	parameter int unsigned NW = TERM_W + RFRAC,
	parameter int unsigned DW = TERM_W + 1,
	parameter int unsigned QW = RATIO_W,
	parameter int unsigned SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vin,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_i,
	output logic          vout,
	output logic [QW-1:0] quot,
	output logic [DW-1:0] den_o,
	output logic [SW-1:0] side_o
);

	localparam int unsigned WW = (NW > DW + QW) ? NW : DW + QW;

	logic          v_s    [0:QW];
	logic [WW-1:0] rem_s  [0:QW];
	logic [DW-1:0] den_s  [0:QW];
	logic [QW-1:0] q_s    [0:QW];
	logic [SW-1:0] side_s [0:QW];

	assign v_s[0]    = vin;
	assign rem_s[0]  = WW'(num);
	assign den_s[0]  = den;
	assign q_s[0]    = '0;
	assign side_s[0] = side_i;

	for (genvar i = 0; i < QW; i++) begin : g_stage
		localparam int unsigned K = QW - 1 - i;
		logic [WW-1:0] sh;
		logic          take;

		always_comb begin
			sh   = WW'(den_s[i]) << K;
			take = rem_s[i] >= sh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= take ? rem_s[i] - sh : rem_s[i];
				q_s[i+1]    <= take ? q_s[i] | (QW'(1) << K) : q_s[i];
				den_s[i+1]  <= den_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign vout   = v_s[QW];
	assign quot   = q_s[QW];
	assign den_o  = den_s[QW];
	assign side_o = side_s[QW];

endmodule

@@ hw/rtl/fresnel_reflectance.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fresnel_reflectance
// unpolarized fresnel reflectance kr from incident direction, normal and index
// ----------------------------------------------------------------------------
// throughput: one request per cycle; the whole pipeline advances together and
//   holds when the output register is full and not taken
// depth is set by the two bit-serial square roots (29 stages each), the sin_t
//   divider (28 stages) and the ratio dividers (31 stages)
// reset: arst_n clears all stage valid bits; payload registers are not reset
// ----------------------------------------------------------------------------
module fresnel_reflectance
	import fr_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [COORD_W-1:0]  incident_x,
	input  logic signed [COORD_W-1:0]  incident_y,
	input  logic signed [COORD_W-1:0]  incident_z,
	input  logic signed [COORD_W-1:0]  normal_x,
	input  logic signed [COORD_W-1:0]  normal_y,
	input  logic signed [COORD_W-1:0]  normal_z,
	input  logic        [IOR_W-1:0]    refr_index,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic        [REFL_W-1:0]   reflectance
);

	localparam logic signed [DOT_W-1:0] DOT_ONE = 34'sd268435456;
	localparam logic signed [DOT_W-1:0] DOT_NEG = -34'sd268435456;

	localparam int unsigned N1_W  = IOR_W + COS_W;       // eta_i * sin_i
	localparam int unsigned ST_W  = 28;                  // sin_t below 1.0
	localparam int unsigned SS1_W = 2 * IOR_W + C16_W;   // eta_i, eta_t, ca16
	localparam int unsigned SS2_W = SS1_W + 1;           // plus tir
	localparam int unsigned SD1_W = IOR_W + C16_W + 1;   // eta_i, ca16, tir
	localparam int unsigned RN_W  = TERM_W + RFRAC;
	localparam int unsigned RD_W  = TERM_W + 1;
	localparam int unsigned RSQ_W = 2 * RATIO_W;

	// the whole pipe moves whenever the output slot is free or being emptied
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// ---------------- stage 1: component products, index floor ----------------
	logic                     v_s1;
	logic signed [31:0]       p0_s1, p1_s1, p2_s1;
	logic        [IOR_W-1:0]  ior_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1  <= incident_x * normal_x;
			p1_s1  <= incident_y * normal_y;
			p2_s1  <= incident_z * normal_z;
			// indices under 0.25 are raised to 0.25
			ior_s1 <= (refr_index < MIN_INDEX) ? MIN_INDEX : refr_index;
		end
	end

	// ---------------- stage 2: dot sum, clamp, side select ----------------
	logic signed [DOT_W-1:0] dot_sum, dot_cl;
	logic                    leaving;

	always_comb begin
		dot_sum = DOT_W'(p0_s1) + DOT_W'(p1_s1) + DOT_W'(p2_s1);
		if (dot_sum > DOT_ONE)
			dot_cl = DOT_ONE;
		else if (dot_sum < DOT_NEG)
			dot_cl = DOT_NEG;
		else
			dot_cl = dot_sum;
		// positive cosine: ray exits the material, indices swap
		leaving = dot_cl > 0;
	end

	logic             v_s2;
	logic [IOR_W-1:0] eta_i_s2, eta_t_s2;
	logic [COS_W-1:0] ca_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eta_i_s2 <= leaving ? ior_s1 : ONE_Q12;
			eta_t_s2 <= leaving ? ONE_Q12 : ior_s1;
			ca_s2    <= leaving ? dot_cl[COS_W-1:0] : COS_W'(-dot_cl);
		end
	end

	// ---------------- stage 3: cos_i squared ----------------
	logic             v_s3;
	logic [SQ_W-1:0]  casq_s3;
	logic [IOR_W-1:0] eta_i_s3, eta_t_s3;
	logic [C16_W-1:0] ca16_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			casq_s3  <= SQ_W'(ca_s2 * ca_s2);
			eta_i_s3 <= eta_i_s2;
			eta_t_s3 <= eta_t_s2;
			ca16_s3  <= ca_s2[COS_W-1:12];
		end
	end

	// ---------------- stage 4: 1 - cos_i^2 ----------------
	logic             v_s4;
	logic [SQ_W-1:0]  sv1_s4;
	logic [SS1_W-1:0] ss1_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sv1_s4 <= ONE_SQ - casq_s3;
			ss1_s4 <= {eta_i_s3, eta_t_s3, ca16_s3};
		end
	end

	// ---------------- sin_i root ----------------
	logic             si_v;
	logic [COS_W-1:0] si;
	logic [SS1_W-1:0] si_side;

	fr_sqrt #(
		.W  (SQ_W),
		.SW (SS1_W)
	) u_sqrt_sin (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vin    (v_s4),
		.rad    (sv1_s4),
		.side_i (ss1_s4),
		.vout   (si_v),
		.root   (si),
		.side_o (si_side)
	);

	// ---------------- stage 5: eta_i * sin_i ----------------
	logic             v_s5;
	logic [N1_W-1:0]  num1_s5;
	logic [IOR_W-1:0] eta_i_s5, eta_t_s5;
	logic [C16_W-1:0] ca16_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= si_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num1_s5                       <= si_side[SS1_W-1 -: IOR_W] * si;
			{eta_i_s5, eta_t_s5, ca16_s5} <= si_side;
		end
	end

	// ---------------- stage 6: total internal reflection test ----------------
	// sin_t >= 1.0 exactly when eta_i * sin_i >= eta_t << 28
	logic             v_s6;
	logic [N1_W-1:0]  num1_s6;
	logic [IOR_W-1:0] eta_t_s6;
	logic [SD1_W-1:0] sd1_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num1_s6  <= num1_s5;
			eta_t_s6 <= eta_t_s5;
			sd1_s6   <= {eta_i_s5, ca16_s5, num1_s5 >= (N1_W'(eta_t_s5) << ST_W)};
		end
	end

	// ---------------- sin_t divide ----------------
	logic             st_v;
	logic [ST_W-1:0]  st;
	logic [IOR_W-1:0] st_den;
	logic [SD1_W-1:0] st_side;

	fr_div #(
		.NW (N1_W),
		.DW (IOR_W),
		.QW (ST_W),
		.SW (SD1_W)
	) u_div_sin (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vin    (v_s6),
		.num    (num1_s6),
		.den    (eta_t_s6),
		.side_i (sd1_s6),
		.vout   (st_v),
		.quot   (st),
		.den_o  (st_den),
		.side_o (st_side)
	);

	// ---------------- stage 7: sin_t squared ----------------
	logic             v_s7;
	logic [SQ_W-1:0]  stsq_s7;
	logic [SS2_W-1:0] ss2_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= st_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stsq_s7 <= SQ_W'(st * st);
			// repack as eta_i, eta_t, ca16, tir
			ss2_s7  <= {st_side[SD1_W-1 -: IOR_W], st_den, st_side[C16_W:0]};
		end
	end

	// ---------------- stage 8: 1 - sin_t^2 ----------------
	logic             v_s8;
	logic [SQ_W-1:0]  sv2_s8;
	logic [SS2_W-1:0] ss2_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sv2_s8 <= ONE_SQ - stsq_s7;
			ss2_s8 <= ss2_s7;
		end
	end

	// ---------------- cos_t root ----------------
	logic             ct_v;
	logic [COS_W-1:0] ct;
	logic [SS2_W-1:0] ct_side;

	fr_sqrt #(
		.W  (SQ_W),
		.SW (SS2_W)
	) u_sqrt_cos (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vin    (v_s8),
		.rad    (sv2_s8),
		.side_i (ss2_s8),
		.vout   (ct_v),
		.root   (ct),
		.side_o (ct_side)
	);

	// ---------------- stage 9: ratio terms ----------------
	logic [IOR_W-1:0] ct_eta_i, ct_eta_t;
	logic [C16_W-1:0] ct_ca16, ct16;
	logic             ct_tir;

	assign {ct_eta_i, ct_eta_t, ct_ca16, ct_tir} = ct_side;
	assign ct16 = ct[COS_W-1:12];

	logic              v_s9, tir_s9;
	logic [TERM_W-1:0] as_s9, bs_s9, ap_s9, bp_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= ct_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			as_s9  <= ct_eta_t * ct_ca16;
			bs_s9  <= ct_eta_i * ct16;
			ap_s9  <= ct_eta_i * ct_ca16;
			bp_s9  <= ct_eta_t * ct16;
			tir_s9 <= ct_tir;
		end
	end

	// ---------------- stage 10: ratio numerators and denominators ----------------
	logic              v_s10, tir_s10, zs_s10, zp_s10;
	logic [TERM_W-1:0] ns_s10, np_s10;
	logic [RD_W-1:0]   ds_s10, dp_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ns_s10  <= (as_s9 >= bs_s9) ? as_s9 - bs_s9 : bs_s9 - as_s9;
			np_s10  <= (ap_s9 >= bp_s9) ? ap_s9 - bp_s9 : bp_s9 - ap_s9;
			ds_s10  <= RD_W'(as_s9) + RD_W'(bs_s9);
			dp_s10  <= RD_W'(ap_s9) + RD_W'(bp_s9);
			// zero denominator only when both terms vanish
			zs_s10  <= (as_s9 == '0) && (bs_s9 == '0);
			zp_s10  <= (ap_s9 == '0) && (bp_s9 == '0);
			tir_s10 <= tir_s9;
		end
	end

	// ---------------- ratio divides, s and p in lockstep ----------------
	logic               rs_v;
	logic [RATIO_W-1:0] qs, qp;
	logic [1:0]         rs_side;
	logic               rp_side;

	fr_div #(
		.NW (RN_W),
		.DW (RD_W),
		.QW (RATIO_W),
		.SW (2)
	) u_div_rs (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vin    (v_s10),
		.num    ({ns_s10, RFRAC'(0)}),
		.den    (ds_s10),
		.side_i ({tir_s10, zs_s10}),
		.vout   (rs_v),
		.quot   (qs),
		.den_o  (),
		.side_o (rs_side)
	);

	fr_div #(
		.NW (RN_W),
		.DW (RD_W),
		.QW (RATIO_W),
		.SW (1)
	) u_div_rp (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vin    (v_s10),
		.num    ({np_s10, RFRAC'(0)}),
		.den    (dp_s10),
		.side_i (zp_s10),
		.vout   (),
		.quot   (qp),
		.den_o  (),
		.side_o (rp_side)
	);

	// ---------------- stage 11: squared ratios ----------------
	logic [RATIO_W-1:0] rs, rp;

	assign rs = rs_side[0] ? RATIO_ONE : qs;
	assign rp = rp_side    ? RATIO_ONE : qp;

	logic             v_s11, tir_s11;
	logic [RSQ_W-1:0] rssq_s11, rpsq_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s11 <= rs_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rssq_s11 <= rs * rs;
			rpsq_s11 <= rp * rp;
			tir_s11  <= rs_side[1];
		end
	end

	// ---------------- stage 12: mean of squares, output register ----------------
	logic [RSQ_W:0] kr_sum;

	assign kr_sum = (RSQ_W + 1)'(rssq_s11) + (RSQ_W + 1)'(rpsq_s11);

	logic              v_s12;
	logic [REFL_W-1:0] refl_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// total internal reflection reflects everything
			refl_s12 <= tir_s11 ? REFL_ONE : kr_sum[61:45];
		end
	end

	assign out_valid   = v_s12;
	assign reflectance = refl_s12;

endmodule

@@ verif/tb_fresnel_reflectance.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fresnel_reflectance
// random and directed requests against a bit-exact fixed-point kr predictor
// ----------------------------------------------------------------------------
module tb_fresnel_reflectance
	import fr_pkg::*;
();

	typedef struct packed {
		logic signed [COORD_W-1:0] ix, iy, iz, nx, ny, nz;
		logic [IOR_W-1:0] ior;
	} ray_hit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [COORD_W-1:0] incident_x = '0, incident_y = '0, incident_z = '0;
	logic signed [COORD_W-1:0] normal_x = '0, normal_y = '0, normal_z = '0;
	logic [IOR_W-1:0] refr_index = 16'd4096;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [REFL_W-1:0] reflectance;

	ray_hit_t hit_q[$];
	logic [REFL_W-1:0] kr_q[$];
	int mismatches = 0;
	bit stim_done = 1'b0;
	int gap_left = 0;
	int stall_left = 0;

	fresnel_reflectance dut (.*);

	always #5 clk = ~clk;

	// bit-serial integer square root, floor
	function automatic logic [63:0] root_floor(input logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	// |a - b| / (a + b) in q0.30
	function automatic logic [63:0] fresnel_ratio(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] num, den;
		num = (a >= b) ? a - b : b - a;
		den = a + b;
		if (den == 0) return 64'd1 << 30;
		return (num << 30) / den;
	endfunction

	function automatic logic [REFL_W-1:0] predict_kr(input ray_hit_t h);
		longint dot;
		logic [63:0] ior, eta_i, eta_t, ca, si, st, ct, rs, rp;
		dot = longint'(h.ix) * h.nx + longint'(h.iy) * h.ny + longint'(h.iz) * h.nz;
		ior = h.ior;
		if (ior < MIN_INDEX) ior = MIN_INDEX;
		// overlong vectors saturate at +-1.0
		if (dot > (64'sd1 << 28)) dot = 64'sd1 << 28;
		if (dot < -(64'sd1 << 28)) dot = -(64'sd1 << 28);
		// leaving the material swaps the indices
		if (dot > 0) begin
			eta_i = ior; eta_t = ONE_Q12; ca = dot;
		end else begin
			eta_i = ONE_Q12; eta_t = ior; ca = -dot;
		end
		si = root_floor((64'd1 << 56) - ca * ca);
		st = (eta_i * si) / eta_t;
		if (st >= (64'd1 << 28)) return REFL_ONE; // total internal reflection
		ct = root_floor((64'd1 << 56) - st * st);
		rs = fresnel_ratio(eta_t * (ca >> 12), eta_i * (ct >> 12));
		rp = fresnel_ratio(eta_i * (ca >> 12), eta_t * (ct >> 12));
		return REFL_W'((rs * rs + rp * rp) >> 45);
	endfunction

	function automatic int draw_gap();
		if ($urandom_range(0, 9) < 6) return 0;
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// random hit: components bounded to +-1.0 along a random axis mix, or raw random words
	function automatic ray_hit_t rand_hit();
		ray_hit_t h;
		int mode;
		h = ray_hit_t'({$urandom, $urandom, $urandom, $urandom});
		mode = $urandom_range(0, 3);
		if (mode < 3) begin
			// mostly bounded components, within +-1.0, to land in the sensible region
			h.ix = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
			h.iy = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
			h.iz = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
			h.nx = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
			h.ny = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
			h.nz = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
			h.ior = IOR_W'($urandom_range(3000, 12000));
		end
		return h;
	endfunction

	initial begin
		ray_hit_t h;
		logic signed [COORD_W-1:0] ext[4];
		ext = '{16'sh8000, 16'sh7fff, 16'sh4000, 16'sh0000};
		// head-on entering glass, leaving glass, grazing
		hit_q.push_back('{16'sh0000, 16'sh0000, -16'sh4000, 0, 0, 16'sh4000, 16'd6144});
		hit_q.push_back('{16'sh0000, 16'sh0000, 16'sh4000, 0, 0, 16'sh4000, 16'd6144});
		hit_q.push_back('{16'sh4000, 0, 0, 0, 0, 16'sh4000, 16'd6144});
		// shallow exit beyond the critical angle
		hit_q.push_back('{16'sh3800, 0, 16'sh0800, 0, 0, 16'sh4000, 16'd8192});
		// index below the floor, and the extremes of the index
		hit_q.push_back('{0, 0, -16'sh4000, 0, 0, 16'sh4000, 16'd0});
		hit_q.push_back('{0, 0, -16'sh2000, 0, 0, 16'sh4000, 16'd1023});
		hit_q.push_back('{0, 0, 16'sh2000, 0, 0, 16'sh4000, 16'hffff});
		hit_q.push_back('{0, 0, -16'sh2000, 0, 0, 16'sh4000, 16'd4096});
		// overlong vectors drive the clamp both ways
		for (int k = 0; k < 4; k++) begin
			h.ix = ext[k]; h.iy = ext[3 - k]; h.iz = ext[k];
			h.nx = ext[(k + 1) % 4]; h.ny = ext[k]; h.nz = ext[(k + 2) % 4];
			h.ior = IOR_W'(32'hffff - k * 32'h3fff);
			hit_q.push_back(h);
		end
		hit_q.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
			16'sh7fff, 16'd5000});
		hit_q.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
			16'sh7fff, 16'd5000});
		for (int k = 0; k < 600; k++) hit_q.push_back(rand_hit());
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				kr_q.push_back(predict_kr({incident_x, incident_y, incident_z,
					normal_x, normal_y, normal_z, refr_index}));
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0 || hit_q.size() == 0) begin
					in_valid <= 1'b0;
					if (gap_left > 0) gap_left <= gap_left - 1;
					if (hit_q.size() == 0 && !(in_valid && in_ready) && !in_valid)
						stim_done <= 1'b1;
				end else begin
					ray_hit_t h;
					h = hit_q.pop_front();
					in_valid <= 1'b1;
					{incident_x, incident_y, incident_z, normal_x, normal_y,
						normal_z, refr_index} <= h;
					gap_left <= draw_gap();
				end
			end
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (kr_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected reflectance %0d", reflectance);
				end else begin
					logic [REFL_W-1:0] exp_kr;
					exp_kr = kr_q.pop_front();
					if (reflectance !== exp_kr) begin
						mismatches++;
						if (mismatches <= 10)
							$display("reflectance mismatch: expected %0d, got %0d",
								exp_kr, reflectance);
					end
				end
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				out_ready <= 1'b1;
				stall_left <= draw_gap();
			end
		end
	end

	initial begin
		wait (stim_done && kr_q.size() == 0);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && kr_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
